@@ rtl/att_pkg.sv @@
// Shared types and constants for the ANSI text terminal.
`default_nettype none
package att_pkg;

    localparam int COLUMNS_DEF    = 80;
    localparam int ROWS_DEF       = 25;
    localparam int MAX_PARAMS_DEF = 16;
    localparam int SEQ_LIMIT_DEF  = 32;

    localparam logic [3:0] FG_RESET = 4'd2;
    localparam logic [3:0] BG_RESET = 4'd0;
    localparam logic [6:0] CH_SPACE = 7'd32;
    localparam logic [7:0] ESC_BYTE = 8'h1B;
    localparam logic [0:0] CMD_FEED = 1'b0;
    localparam logic [0:0] CMD_READ = 1'b1;

    typedef struct packed {
        logic [0:0] command;
        logic [7:0] data_byte;
        logic [4:0] read_row;
        logic [6:0] read_column;
    } t_in_word;

    typedef struct packed {
        logic [6:0] cell_char;
        logic [3:0] cell_fg;
        logic [3:0] cell_bg;
        logic       cell_bold;
        logic       cell_underline;
        logic [6:0] cursor_column;
        logic [4:0] cursor_row;
    } t_out_word;

    // cell layout: underline, bold, bg, fg, char
    typedef struct packed {
        logic       ul;
        logic       bold;
        logic [3:0] bg;
        logic [3:0] fg;
        logic [6:0] ch;
    } t_cell;

    // datapath memory operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_READ,      // read address
        OP_WRITE,     // write full cell
        OP_BLANK,     // rewrite char of read data to space
        OP_COPY       // write read data unchanged
    } t_mem_op;

    typedef struct packed {
        t_mem_op     op;
        logic [11:0] rd_addr;
        logic [11:0] wr_addr;
        t_cell       wr_cell;
    } t_mem_cmd;

    typedef struct packed {
        t_cell rd_cell;
    } t_mem_sts;

endpackage
`default_nettype wire

@@ rtl/att_ram.sv @@
// Generic single-port-write, one-read RAM with registered read.
`default_nettype none
module att_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/att_datapath.sv @@
// Screen memory datapath: executes read, write, blank and copy commands.
`default_nettype none
module att_datapath
    import att_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  wire logic     i_clk,
    input  wire t_mem_cmd i_cmd,
    output t_mem_sts      o_sts
);
    localparam int DEPTH = COLUMNS * ROWS;
    localparam int AW    = $clog2(DEPTH);

    t_cell w_rdata;
    t_cell w_wdata;
    logic  w_we;

    always_comb begin
        w_we    = 1'b0;
        w_wdata = i_cmd.wr_cell;
        case (i_cmd.op)
            OP_WRITE: w_we = 1'b1;
            OP_BLANK: begin
                w_we       = 1'b1;
                w_wdata    = w_rdata;
                w_wdata.ch = CH_SPACE;
            end
            OP_COPY: begin
                w_we    = 1'b1;
                w_wdata = w_rdata;
            end
            default: w_we = 1'b0;
        endcase
    end

    att_ram #(.WIDTH($bits(t_cell)), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(i_cmd.wr_addr[AW-1:0]),
        .i_wdata(w_wdata),
        .i_raddr(i_cmd.rd_addr[AW-1:0]),
        .o_rdata(w_rdata)
    );

    assign o_sts.rd_cell = w_rdata;
endmodule
`default_nettype wire

@@ rtl/att_ctrl.sv @@
// Terminal controller: byte parser, cursor, attributes and memory sweeps.
`default_nettype none
module att_ctrl
    import att_pkg::*;
#(
    parameter int COLUMNS    = COLUMNS_DEF,
    parameter int ROWS       = ROWS_DEF,
    parameter int MAX_PARAMS = MAX_PARAMS_DEF,
    parameter int SEQ_LIMIT  = SEQ_LIMIT_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_word i_data,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_out_word     o_data,
    output t_mem_cmd      o_cmd,
    input  wire t_mem_sts i_sts
);
    localparam int DEPTH = COLUMNS * ROWS;
    localparam int PW    = $clog2(MAX_PARAMS + 2);
    localparam int IW    = $clog2(MAX_PARAMS);
    localparam logic [6:0] COLS7 = 7'(COLUMNS);
    localparam logic [4:0] ROWS5 = 5'(ROWS);
    localparam logic [11:0] DEPTH12 = 12'(DEPTH);
    localparam logic [11:0] COLS12  = 12'(COLUMNS);
    localparam logic [11:0] LASTROW = 12'((ROWS - 1) * COLUMNS);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_RD_WAIT, S_RD_TAKE, S_DECODE, S_SCROLL_RD, S_SCROLL_CLR,
        S_PUT, S_BLANK, S_FILL, S_SGR, S_OUT
    } t_state;

    t_state      r_state;
    logic [11:0] r_ptr;       // sweep address
    logic [11:0] r_end;       // sweep end (exclusive)
    logic        r_after_put; // scroll is followed by a put
    logic        r_blank_rd;  // blank sweep read already issued
    logic [6:0]  r_cx;
    logic [4:0]  r_cy;
    logic [6:0]  r_sx;
    logic [4:0]  r_sy;
    logic [3:0]  r_fg;
    logic [3:0]  r_bg;
    logic [2:0]  r_fl;
    logic [4:0]  r_elen;
    logic [15:0] r_pv [MAX_PARAMS];
    logic [PW-1:0] r_pc;
    logic [IW-1:0] r_si;
    logic [PW-1:0] r_sn;
    t_in_word    r_in;
    t_out_word   r_out;
    logic        r_ov;
    t_mem_cmd    r_cmd;

    t_cell w_blank;
    assign w_blank = '{ul: r_fl[1], bold: r_fl[0], bg: r_bg, fg: r_fg, ch: CH_SPACE};

    logic [7:0]  c;
    logic        w_letter, w_digit;
    logic [15:0] p0, p1, step;
    logic [PW-1:0] w_n;
    logic [IW-1:0] w_pidx;
    always_comb begin
        c        = r_in.data_byte;
        w_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
        w_digit  = (c >= 8'h30 && c <= 8'h39);
        w_n      = (r_pc > PW'(MAX_PARAMS)) ? PW'(MAX_PARAMS) : r_pc;
        p0       = (w_n > 0) ? r_pv[0] : 16'd0;
        p1       = (w_n > 1) ? r_pv[1] : 16'd0;
        step     = (p0 > 0) ? p0 : 16'd1;
        w_pidx   = IW'(r_pc - PW'(1));
    end

    // wider stores of 10*v+d saturate
    logic [19:0] w_mac_full;
    assign w_mac_full = 20'({r_pv[w_pidx], 3'b0}) + 20'({r_pv[w_pidx], 1'b0}) + 20'(c[3:0]);

    logic [15:0] w_code;
    assign w_code = r_pv[r_si];

    always_ff @(posedge i_clk) begin
        r_cmd.op <= OP_NONE;
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ptr <= '0;
            r_cx <= '0; r_cy <= '0; r_sx <= '0; r_sy <= '0;
            r_fg <= FG_RESET; r_bg <= BG_RESET; r_fl <= '0;
            r_elen <= '0; r_pc <= '0;
            for (int i = 0; i < MAX_PARAMS; i++) r_pv[i] <= '0;
            r_ov <= 1'b0;
            r_after_put <= 1'b0;
            r_blank_rd <= 1'b0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_state)
            S_INIT: begin
                // clearing pass over screen memory
                r_cmd.op      <= OP_WRITE;
                r_cmd.wr_addr <= r_ptr;
                r_cmd.wr_cell <= w_blank;
                if (r_ptr == DEPTH12 - 12'd1) begin
                    r_state <= S_IDLE;
                end
                r_ptr <= r_ptr + 12'd1;
            end
            S_IDLE: begin
                if (i_valid && !r_ov) begin
                    r_in <= i_data;
                    r_out <= '0;
                    if (i_data.command == CMD_READ) begin
                        r_cmd.op      <= OP_READ;
                        r_cmd.rd_addr <= 12'(i_data.read_row) * COLS12
                                       + 12'(i_data.read_column);
                        r_state <= S_RD_WAIT;
                    end else begin
                        r_state <= S_DECODE;
                    end
                end
            end
            S_RD_WAIT: r_state <= S_RD_TAKE;
            S_RD_TAKE: begin
                if (r_in.read_row < ROWS5 && r_in.read_column < COLS7) begin
                    r_out.cell_char      <= i_sts.rd_cell.ch;
                    r_out.cell_fg        <= i_sts.rd_cell.fg;
                    r_out.cell_bg        <= i_sts.rd_cell.bg;
                    r_out.cell_bold      <= i_sts.rd_cell.bold;
                    r_out.cell_underline <= i_sts.rd_cell.ul;
                end
                r_state <= S_OUT;
            end
            S_DECODE: begin
                r_state <= S_OUT;
                if (r_elen != 0) begin
                    r_elen <= r_elen + 5'd1;
                    if (w_letter) begin
                        r_elen <= '0;
                        case (c)
                        8'h48, 8'h66: begin
                            r_cy <= (p0 == 0) ? 5'd0 :
                                    ((p0 - 16'd1 < 16'(ROWS - 1)) ? 5'(p0 - 16'd1)
                                                                   : 5'(ROWS - 1));
                            r_cx <= (p1 == 0) ? 7'd0 :
                                    ((p1 - 16'd1 < 16'(COLUMNS - 1)) ? 7'(p1 - 16'd1)
                                                                      : 7'(COLUMNS - 1));
                        end
                        8'h41: r_cy <= (step >= 16'(r_cy)) ? 5'd0 : r_cy - 5'(step);
                        8'h42: r_cy <= (17'(r_cy) + 17'(step) >= 17'(ROWS))
                                       ? 5'(ROWS - 1) : r_cy + 5'(step);
                        8'h43: r_cx <= (17'(r_cx) + 17'(step) >= 17'(COLUMNS))
                                       ? 7'(COLUMNS - 1) : r_cx + 7'(step);
                        8'h44: r_cx <= (step >= 16'(r_cx)) ? 7'd0 : r_cx - 7'(step);
                        8'h4A: begin
                            if (p0 == 16'd2) begin
                                r_ptr <= '0; r_end <= DEPTH12;
                                r_cx <= '0; r_cy <= '0;
                                r_state <= S_FILL;
                            end else if (p0 == 16'd0 && r_cy < ROWS5 && r_cx < COLS7) begin
                                r_ptr <= 12'(r_cy) * COLS12 + 12'(r_cx);
                                r_end <= DEPTH12;
                                r_blank_rd <= 1'b0;
                                r_state <= S_BLANK;
                            end else if (p0 == 16'd0 && r_cy < ROWS5 - 5'd1) begin
                                r_ptr <= 12'(r_cy + 5'd1) * COLS12;
                                r_end <= DEPTH12;
                                r_blank_rd <= 1'b0;
                                r_state <= S_BLANK;
                            end
                        end
                        8'h4B: begin
                            if (r_cy < ROWS5) begin
                                if (p0 == 16'd0 && r_cx < COLS7) begin
                                    r_ptr <= 12'(r_cy) * COLS12 + 12'(r_cx);
                                    r_end <= 12'(r_cy) * COLS12 + COLS12;
                                    r_blank_rd <= 1'b0;
                                    r_state <= S_BLANK;
                                end else if (p0 == 16'd1) begin
                                    r_ptr <= 12'(r_cy) * COLS12;
                                    r_end <= 12'(r_cy) * COLS12 +
                                             ((r_cx < COLS7) ? 12'(r_cx) + 12'd1 : COLS12);
                                    r_blank_rd <= 1'b0;
                                    r_state <= S_BLANK;
                                end else if (p0 == 16'd2) begin
                                    r_ptr <= 12'(r_cy) * COLS12;
                                    r_end <= 12'(r_cy) * COLS12 + COLS12;
                                    r_state <= S_FILL;
                                end
                            end
                        end
                        8'h6D: begin
                            r_si <= '0; r_sn <= w_n;
                            r_state <= S_SGR;
                        end
                        8'h73: begin r_sx <= r_cx; r_sy <= r_cy; end
                        8'h75: begin r_cx <= r_sx; r_cy <= r_sy; end
                        default: ;
                        endcase
                    end else begin
                        if (c == 8'h5B && r_elen == 5'd1) begin
                            r_pc <= PW'(1);
                            r_pv[0] <= '0;
                        end else if (w_digit) begin
                            if (r_pc >= PW'(1) && r_pc <= PW'(MAX_PARAMS)) begin
                                r_pv[w_pidx] <= (w_mac_full > 20'd65535) ? 16'hFFFF
                                                : w_mac_full[15:0];
                            end
                        end else if (c == 8'h3B) begin
                            if (r_pc >= PW'(1) && r_pc < PW'(MAX_PARAMS)) begin
                                r_pv[IW'(r_pc)] <= '0;
                                r_pc <= r_pc + PW'(1);
                            end else if (r_pc == PW'(MAX_PARAMS)) begin
                                r_pc <= PW'(MAX_PARAMS + 1);
                            end
                        end
                        if (r_elen + 5'd1 >= 5'(SEQ_LIMIT - 1)) r_elen <= '0;
                    end
                end else if (c == ESC_BYTE) begin
                    r_elen <= 5'd1;
                    r_pc <= '0;
                    for (int i = 0; i < MAX_PARAMS; i++) r_pv[i] <= '0;
                end else if (c == 8'h0D) begin
                    r_cx <= '0;
                end else if (c == 8'h0A) begin
                    r_cx <= '0;
                    if (6'(r_cy) + 6'd1 >= 6'(ROWS)) begin
                        r_cy <= ROWS5 - 5'd1;
                        r_ptr <= '0; r_after_put <= 1'b0;
                        r_state <= S_SCROLL_RD;
                    end else begin
                        r_cy <= r_cy + 5'd1;
                    end
                end else if (c == 8'h09) begin
                    if (((8'(r_cx) + 8'd8) & 8'hF8) >= 8'(COLUMNS)) begin
                        r_cx <= '0;
                        if (r_cy < ROWS5) r_cy <= r_cy + 5'd1;
                    end else begin
                        r_cx <= 7'((8'(r_cx) + 8'd8) & 8'hF8);
                    end
                end else if (c == 8'h08) begin
                    if (r_cx != 0) r_cx <= r_cx - 7'd1;
                end else if (c >= 8'h20 && c <= 8'h7E) begin
                    if (r_cy >= ROWS5) begin
                        r_cy <= ROWS5 - 5'd1;
                        r_ptr <= '0; r_after_put <= 1'b1;
                        r_state <= S_SCROLL_RD;
                    end else if (r_cx >= COLS7) begin
                        r_cx <= '0;
                        if (r_cy + 5'd1 >= ROWS5) begin
                            r_cy <= ROWS5 - 5'd1;
                            r_ptr <= '0; r_after_put <= 1'b1;
                            r_state <= S_SCROLL_RD;
                        end else begin
                            r_cy <= r_cy + 5'd1;
                            r_state <= S_PUT;
                        end
                    end else begin
                        r_state <= S_PUT;
                    end
                end
            end
            S_SCROLL_RD: begin
                // read ptr+COLUMNS, copy it to ptr when data returns
                if (r_ptr == LASTROW) begin
                    r_end <= DEPTH12;
                    r_state <= S_SCROLL_CLR;
                end else begin
                    r_cmd.op      <= OP_READ;
                    r_cmd.rd_addr <= r_ptr + COLS12;
                    r_state <= S_SCROLL_CLR;
                    r_end <= r_ptr;
                end
            end
            S_SCROLL_CLR: begin
                if (r_end != DEPTH12) begin
                    // copy the cell read from r_end+COLUMNS into r_end
                    r_cmd.op      <= OP_COPY;
                    r_cmd.wr_addr <= r_end;
                    r_ptr <= r_ptr + 12'd1;
                    r_state <= S_SCROLL_RD;
                end else begin
                    // clear last row through fill
                    r_ptr <= LASTROW;
                    r_end <= DEPTH12;
                    r_state <= S_FILL;
                end
            end
            S_FILL: begin
                r_cmd.op      <= OP_WRITE;
                r_cmd.wr_addr <= r_ptr;
                r_cmd.wr_cell <= w_blank;
                r_ptr <= r_ptr + 12'd1;
                if (r_ptr + 12'd1 == r_end) begin
                    r_state <= r_after_put ? S_PUT : S_OUT;
                    r_after_put <= 1'b0;
                end
            end
            S_PUT: begin
                r_cmd.op      <= OP_WRITE;
                r_cmd.wr_addr <= 12'(r_cy) * COLS12 + 12'(r_cx);
                r_cmd.wr_cell <= '{ul: r_fl[1], bold: r_fl[0], bg: r_bg, fg: r_fg,
                                   ch: c[6:0]};
                r_cx <= r_cx + 7'd1;
                r_state <= S_OUT;
            end
            S_BLANK: begin
                // each cell is read, then rewritten
                if (!r_blank_rd) begin
                    r_cmd.op      <= OP_READ;
                    r_cmd.rd_addr <= r_ptr;
                    r_blank_rd <= 1'b1;
                end else begin
                    r_cmd.op      <= OP_BLANK;
                    r_cmd.wr_addr <= r_ptr;
                    r_blank_rd <= 1'b0;
                    r_ptr <= r_ptr + 12'd1;
                    if (r_ptr + 12'd1 == r_end) r_state <= S_OUT;
                end
            end
            S_SGR: begin
                if (PW'(r_si) >= r_sn) begin
                    r_state <= S_OUT;
                end else begin
                    if (w_code == 16'd0) begin
                        r_fg <= FG_RESET; r_bg <= BG_RESET; r_fl <= '0;
                    end else if (w_code == 16'd1) r_fl[0] <= 1'b1;
                    else if (w_code == 16'd4) r_fl[1] <= 1'b1;
                    else if (w_code == 16'd7) begin
                        r_fl[2] <= 1'b1; r_fg <= r_bg; r_bg <= r_fg;
                    end else if (w_code >= 16'd30 && w_code <= 16'd37)
                        r_fg <= {r_fl[0], 3'(w_code - 16'd30)};
                    else if (w_code >= 16'd40 && w_code <= 16'd47)
                        r_bg <= {1'b0, w_code[2:0]};
                    else if (w_code >= 16'd90 && w_code <= 16'd97)
                        r_fg <= {1'b1, 3'(w_code - 16'd90)};
                    else if (w_code >= 16'd100 && w_code <= 16'd107)
                        r_bg <= {1'b1, 3'(w_code - 16'd100)};
                    if (PW'(r_si) + PW'(1) >= r_sn) r_state <= S_OUT;
                    else r_si <= r_si + IW'(1);
                end
            end
            S_OUT: begin
                r_out.cursor_column <= r_cx;
                r_out.cursor_row    <= r_cy;
                r_ov <= 1'b1;
                r_state <= S_IDLE;
            end
            default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_data  = r_out;
    assign o_cmd   = r_cmd;
endmodule
`default_nettype wire

@@ rtl/ansi_text_terminal.sv @@
// Top level of the ANSI text terminal.
`default_nettype none
// Character-cell terminal: each input word either feeds one byte of a
// terminal stream or reads one screen cell; each gives exactly one output
// word with the read cell (zero for bytes) and the cursor afterwards.
// The screen lives in one RAM with one write and one read port; a
// scroll copies (ROWS-1)*COLUMNS cells up and then clears COLUMNS cells,
// a clear J2 or K2 writes each cell as a blank, and partial blanks (J0, K0,
// K1) read each cell and then rewrite it. After reset a clearing pass writes
// all ROWS*COLUMNS cells, one per cycle, before the first word is taken.
module ansi_text_terminal
    import att_pkg::*;
#(
    parameter int COLUMNS    = COLUMNS_DEF,
    parameter int ROWS       = ROWS_DEF,
    parameter int MAX_PARAMS = MAX_PARAMS_DEF,
    parameter int SEQ_LIMIT  = SEQ_LIMIT_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_word i_data,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_out_word     o_data
);
    t_mem_cmd w_cmd;
    t_mem_sts w_sts;

    att_ctrl #(.COLUMNS(COLUMNS), .ROWS(ROWS), .MAX_PARAMS(MAX_PARAMS),
               .SEQ_LIMIT(SEQ_LIMIT)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .o_cmd(w_cmd), .i_sts(w_sts)
    );

    att_datapath #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_dp (
        .i_clk(i_clk), .i_cmd(w_cmd), .o_sts(w_sts)
    );
endmodule
`default_nettype wire

@@ rtl/att_checker.sv @@
// Port-level checker for the ANSI text terminal, bound to the top level.
`default_nettype none
module att_checker
    import att_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_valid,
    input wire logic      o_ready,
    input wire logic      o_valid,
    input wire logic      i_ready,
    input wire t_out_word o_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data)) else $error("out hold");
    a_no_take_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready with pending word");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_valid) else $error("result too early");
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("valid after reset");
endmodule

bind ansi_text_terminal att_checker u_att_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
);
`default_nettype wire
